/* hw/rtl/deq_pkg.sv */
`timescale 1ns / 1ps

package deq_pkg;

  localparam int DEQ_DEPTH = 16;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic [1:0] {
    REQ_PUSH_BACK  = 2'd0,
    REQ_PUSH_FRONT = 2'd1,
    REQ_POP_BACK   = 2'd2,
    REQ_POP_FRONT  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // decoded operation handed from front to back
  typedef struct packed {
    logic             wr;
    logic             rd;
    status_t          status;
    logic [OCC_W-1:0] occ;
  } op_ctl_t;

  localparam int CTL_W = $bits(op_ctl_t);

endpackage

/* hw/rtl/deq_ram.sv */
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/deq_front.sv */
`timescale 1ns / 1ps

module deq_front #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  deq_pkg::req_t            req,
  input  logic [deq_pkg::DATA_W-1:0] value,
  output deq_pkg::op_ctl_t         op_ctl,
  output logic [$clog2(DEPTH)-1:0] op_addr,
  output logic [deq_pkg::DATA_W-1:0] op_data
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int XW = (CW > OCC_W) ? CW : OCC_W;

  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] sum_back, sum_last;
  logic [AW-1:0] addr_back, addr_last, head_dec, head_inc;
  logic [XW-1:0] count_ext;
  logic          full, empty;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // slot after the back, and slot of the back element (one compare and subtract each)
  always_comb begin
    sum_back = SW'(head_r) + SW'(count_r);
    sum_last = SW'(head_r) + SW'(count_r) - SW'(1);
    if (sum_back >= SW'(DEPTH)) begin
      sum_back = sum_back - SW'(DEPTH);
    end
    if (sum_last >= SW'(DEPTH)) begin
      sum_last = sum_last - SW'(DEPTH);
    end
    addr_back = sum_back[AW-1:0];
    addr_last = sum_last[AW-1:0];
    head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  end

  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    op_ctl.wr      = 1'b0;
    op_ctl.rd      = 1'b0;
    op_ctl.status  = ST_OK;
    op_addr        = head_r;
    op_data        = value;
    unique case (req)
      REQ_PUSH_BACK: begin
        if (full) begin
          op_ctl.status = ST_FULL;
        end else begin
          op_ctl.wr = 1'b1;
          op_addr   = addr_back;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_PUSH_FRONT: begin
        if (full) begin
          op_ctl.status = ST_FULL;
        end else begin
          op_ctl.wr = 1'b1;
          op_addr   = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          op_ctl.status = ST_EMPTY;
        end else begin
          op_ctl.rd = 1'b1;
          op_addr   = addr_last;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          op_ctl.status = ST_EMPTY;
        end else begin
          op_ctl.rd = 1'b1;
          op_addr   = head_r;
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        op_ctl.status = ST_OK;
      end
    endcase
    // occupancy wraps to its field width
    count_ext  = XW'(count_nxt);
    op_ctl.occ = count_ext[OCC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (acc) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/deq_opq.sv */
`timescale 1ns / 1ps

module deq_opq #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         has_room,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign has_room  = (cnt_r != 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

/* hw/rtl/deq_back.sv */
`timescale 1ns / 1ps

module deq_back #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  deq_pkg::op_ctl_t             q_ctl,
  input  logic [$clog2(DEPTH)-1:0]     q_addr,
  input  logic [deq_pkg::DATA_W-1:0]   q_data,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output deq_pkg::status_t             out_status,
  output logic [deq_pkg::DATA_W-1:0]   out_popped,
  output logic [deq_pkg::OCC_W-1:0]    out_occ
);

  import deq_pkg::*;

  logic              s1_valid_r, s1_valid_nxt;
  op_ctl_t           s1_ctl_r;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [DATA_W-1:0] out_popped_r;
  logic [OCC_W-1:0]  out_occ_r;
  logic [DATA_W-1:0] ram_rd;
  logic              adv, issue;

  // s1 moves on when the output register is free or being drained
  assign adv   = s1_valid_r && (!out_valid_r || out_ready);
  // RAM read data holds while s1 stalls: nothing issues then
  assign issue = q_valid && (!s1_valid_r || adv);
  assign q_pop = issue;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (issue && q_ctl.wr),
    .wr_addr (q_addr),
    .wr_data (q_data),
    .re      (issue && q_ctl.rd),
    .rd_addr (q_addr),
    .rd_data (ram_rd)
  );

  always_comb begin
    s1_valid_nxt  = issue ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctl_r <= q_ctl;
    end
    if (adv) begin
      out_status_r <= s1_ctl_r.status;
      out_popped_r <= s1_ctl_r.rd ? ram_rd : '0;
      out_occ_r    <= s1_ctl_r.occ;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_popped = out_popped_r;
  assign out_occ    = out_occ_r;

endmodule

/* hw/rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
// Bounded double-ended queue of signed 32-bit words in a ring RAM of DEPTH entries.
// Input channel (in_*): one request per beat; in_tuser carries the request kind
// (push back, push front, pop back, pop front), in_tdata the word to push.
// Output channel (out_*): exactly one result beat per request, in request order;
// out_tuser is the status (ok, empty, full), out_tdata the popped word (zero
// unless a pop succeeded) and the occupancy after the request.
// Front end: checks full/empty against the head and count registers, updates
// them and works out the RAM address in the accept cycle. A two-entry op queue
// sits between it and the back end, which drives the RAM (registered read) and
// the output register.
// When nothing stalls, a request beat is written into the op queue, its op is then
// issued to the RAM, and the result is then taken into the output register, which
// raises out_tvalid. Throughput: one request per cycle sustained while out_tready
// stays high; the back end issues one op a cycle to the RAM unless s1 stalls.
// Reset (rst_n low, synchronous) empties the deque and drops any beat in
// flight; RAM contents are not cleared and need no clearing pass.
// When the receiver holds out_tready low the result is held, the back end
// fills, then the op queue, and in_tready drops after two more requests.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] popped_value, [36:32] occupancy, [39:37] zero
  output logic [1:0]  out_tuser   // [1:0] status
);

  import deq_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int QW  = CTL_W + AW + DATA_W;

  logic              acc;
  op_ctl_t           f_ctl;
  logic [AW-1:0]     f_addr;
  logic [DATA_W-1:0] f_data;
  logic [QW-1:0]     q_out;
  logic              q_room, q_valid, q_pop;
  op_ctl_t           q_ctl;
  logic [AW-1:0]     q_addr;
  logic [DATA_W-1:0] q_data;
  status_t           res_status;
  logic [DATA_W-1:0] res_popped;
  logic [OCC_W-1:0]  res_occ;

  assign in_tready = q_room;
  assign acc       = in_tvalid && q_room;

  deq_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .req     (req_t'(in_tuser)),
    .value   (in_tdata),
    .op_ctl  (f_ctl),
    .op_addr (f_addr),
    .op_data (f_data)
  );

  deq_opq #(
    .W (QW)
  ) u_opq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc),
    .push_data ({f_ctl, f_addr, f_data}),
    .has_room  (q_room),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  assign {q_ctl, q_addr, q_data} = q_out;

  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_addr     (q_addr),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (res_status),
    .out_popped (res_popped),
    .out_occ    (res_occ)
  );

  assign out_tdata = {3'b000, res_occ, res_popped};
  assign out_tuser = res_status;

endmodule
